FILE: sv/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and codes for the UART ring buffer engine: operation and
// error codes, register indexes, the classified command and the result item.
// ----------------------------------------------------------------------------
package urb_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_RX_WORD = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_WRITE   = 2'd2;
    localparam logic [1:0] OP_DRAIN   = 2'd3;

    // error codes, lowest nonzero code has highest priority
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BREAK   = 3'd1;
    localparam logic [2:0] ERR_OVERRUN = 3'd2;
    localparam logic [2:0] ERR_FRAMING = 3'd3;
    localparam logic [2:0] ERR_PARITY  = 3'd4;

    // flag bit positions in a received UART word
    localparam int RXW_FRAMING_BIT = 8;
    localparam int RXW_PARITY_BIT  = 9;
    localparam int RXW_BREAK_BIT   = 10;
    localparam int RXW_OVERRUN_BIT = 11;

    // configuration register indexes
    localparam int               CFG_INDEX_W        = 2;
    localparam int               CFG_DATA_W         = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEWLINE_EXPAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_PATTERN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH   = 2'd2;

    // special bytes
    localparam logic [7:0] BYTE_NL = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // width of the count ports
    localparam int COUNT_W = 10;

    // depth of the command and result queues
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = 1;
    localparam int QUEUE_CW    = 2;

    // classified command from front end to back end
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;      // received byte or byte to transmit
        logic [2:0] err;       // highest-priority flag of a received word
        logic       peek;
        logic       newline;   // byte to transmit is a newline
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [7:0]         rd_data;
        logic               rd_valid;
        logic [2:0]         error_code;
        logic               accepted;
        logic               magic_hit;
        logic [7:0]         tx_data;
        logic               tx_valid;
        logic [COUNT_W-1:0] rx_fill;
        logic [COUNT_W-1:0] tx_room;
    } t_result;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: sv/urb_front.sv
// ----------------------------------------------------------------------------
// urb_front
// Input side: takes items, classifies them into commands and holds them in
// a short queue for the back end.
// ----------------------------------------------------------------------------
module urb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     i_op,
    input  logic [11:0]    i_rx_word,
    input  logic [7:0]     i_data_in,
    input  logic           i_peek_only,
    output urb_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_pop
);

    urb_pkg::t_cmd                      r_q [urb_pkg::QUEUE_DEPTH];
    logic [urb_pkg::QUEUE_PW-1:0]       r_wr_ptr;
    logic [urb_pkg::QUEUE_PW-1:0]       r_rd_ptr;
    logic [urb_pkg::QUEUE_CW-1:0]       r_count;
    logic [urb_pkg::QUEUE_CW-1:0]       n_count;
    urb_pkg::t_cmd                      cmd_in;
    logic                               push_ok;

    // classify: error priority break, overrun, framing, parity
    always_comb begin
        cmd_in.op      = i_op;
        cmd_in.data    = (i_op == urb_pkg::OP_WRITE) ? i_data_in : i_rx_word[7:0];
        cmd_in.peek    = i_peek_only;
        cmd_in.newline = (i_data_in == urb_pkg::BYTE_NL);
        if (i_rx_word[urb_pkg::RXW_BREAK_BIT]) begin
            cmd_in.err = urb_pkg::ERR_BREAK;
        end else if (i_rx_word[urb_pkg::RXW_OVERRUN_BIT]) begin
            cmd_in.err = urb_pkg::ERR_OVERRUN;
        end else if (i_rx_word[urb_pkg::RXW_FRAMING_BIT]) begin
            cmd_in.err = urb_pkg::ERR_FRAMING;
        end else if (i_rx_word[urb_pkg::RXW_PARITY_BIT]) begin
            cmd_in.err = urb_pkg::ERR_PARITY;
        end else begin
            cmd_in.err = urb_pkg::ERR_NONE;
        end
    end

    assign full        = (r_count == urb_pkg::QUEUE_CW'(urb_pkg::QUEUE_DEPTH));
    assign push_ok     = push && !full;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // occupancy
    always_comb begin
        case ({push_ok, i_cmd_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: sv/urb_back.sv
// ----------------------------------------------------------------------------
// urb_back
// Execution side: receive and transmit rings, sticky error, magic matcher
// and configuration registers. One command at a time.
// ----------------------------------------------------------------------------
module urb_back #(
    parameter int RING_DEPTH = 1024,
    parameter int MAGIC_MAX  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [urb_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [urb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  urb_pkg::t_cmd                      i_cmd,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_pop,
    input  logic                               i_res_room,
    output logic                               o_res_push,
    output urb_pkg::t_result                   o_res
);

    localparam int             PW        = $clog2(RING_DEPTH);
    localparam logic [PW-1:0]  LAST      = PW'(RING_DEPTH - 1);
    localparam logic [3:0]     MAGIC_CAP = 4'(MAGIC_MAX);

    // sequencer states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RX_READ = 2'd1;
    localparam logic [1:0] ST_TX_READ = 2'd2;
    localparam logic [1:0] ST_CR      = 2'd3;

    logic [7:0]    r_rx_mem [RING_DEPTH];
    logic [7:0]    r_tx_mem [RING_DEPTH];
    logic [7:0]    r_rx_rdata;
    logic [7:0]    r_tx_rdata;

    logic [1:0]    r_state,   n_state;
    logic [PW-1:0] r_rx_head, n_rx_head;
    logic [PW-1:0] r_rx_tail, n_rx_tail;
    logic [PW-1:0] r_rx_fill, n_rx_fill;
    logic [PW-1:0] r_tx_head, n_tx_head;
    logic [PW-1:0] r_tx_tail, n_tx_tail;
    logic [PW-1:0] r_tx_fill, n_tx_fill;
    logic [2:0]    r_sticky,  n_sticky;
    logic [3:0]    r_match_pos, n_match_pos;
    logic          r_peek,    n_peek;

    logic          r_newline_expand;
    logic [63:0]   r_magic_pattern;
    logic [3:0]    r_magic_length;

    logic          rx_we, rx_re, tx_we, tx_re;
    logic [7:0]    tx_wdata;
    logic [3:0]    magic_len;
    logic          rx_full, tx_full;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [urb_pkg::COUNT_W-1:0] to_count(input logic [PW-1:0] v);
        logic [PW+urb_pkg::COUNT_W-1:0] w;
        w = {{urb_pkg::COUNT_W{1'b0}}, v};
        return w[urb_pkg::COUNT_W-1:0];
    endfunction

    assign magic_len = (r_magic_length > MAGIC_CAP) ? MAGIC_CAP : r_magic_length;
    assign rx_full   = (r_rx_fill == LAST);
    assign tx_full   = (r_tx_fill == LAST);

    // command sequencer
    always_comb begin
        logic [3:0] pos;
        logic [3:0] pos_inc;
        logic [7:0] want;
        logic       hit;
        pos         = (r_match_pos >= magic_len) ? 4'd0 : r_match_pos;
        pos_inc     = pos + 4'd1;
        want        = r_magic_pattern[{pos[2:0], 3'b000} +: 8];
        hit         = 1'b0;
        n_state     = r_state;
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_rx_fill   = r_rx_fill;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_tx_fill   = r_tx_fill;
        n_sticky    = r_sticky;
        n_match_pos = r_match_pos;
        n_peek      = r_peek;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        tx_wdata    = i_cmd.data;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_res_room) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        urb_pkg::OP_RX_WORD: begin
                            if (r_sticky == urb_pkg::ERR_NONE) begin
                                n_sticky = i_cmd.err;
                            end
                            // naive matcher: restart at zero on mismatch or hit
                            if (magic_len != 4'd0) begin
                                if (i_cmd.data == want) begin
                                    if (pos_inc >= magic_len) begin
                                        hit         = 1'b1;
                                        n_match_pos = 4'd0;
                                    end else begin
                                        n_match_pos = pos_inc;
                                    end
                                end else begin
                                    n_match_pos = 4'd0;
                                end
                            end
                            // byte dropped on full ring
                            if (!rx_full) begin
                                rx_we     = 1'b1;
                                n_rx_head = ring_next(r_rx_head);
                                n_rx_fill = r_rx_fill + 1'b1;
                            end else if (n_sticky == urb_pkg::ERR_NONE) begin
                                n_sticky = urb_pkg::ERR_OVERRUN;
                            end
                            o_res.magic_hit = hit;
                            o_res_push      = 1'b1;
                        end
                        urb_pkg::OP_READ: begin
                            if (r_sticky != urb_pkg::ERR_NONE) begin
                                o_res.error_code = r_sticky;
                                n_sticky         = urb_pkg::ERR_NONE;
                                o_res_push       = 1'b1;
                            end else if (r_rx_fill == '0) begin
                                o_res_push = 1'b1;
                            end else begin
                                rx_re   = 1'b1;
                                n_peek  = i_cmd.peek;
                                n_state = ST_RX_READ;
                            end
                        end
                        urb_pkg::OP_WRITE: begin
                            if (tx_full) begin
                                o_res_push = 1'b1;
                            end else begin
                                tx_we     = 1'b1;
                                n_tx_head = ring_next(r_tx_head);
                                n_tx_fill = r_tx_fill + 1'b1;
                                if (i_cmd.newline && r_newline_expand) begin
                                    n_state = ST_CR;
                                end else begin
                                    o_res.accepted = 1'b1;
                                    o_res_push     = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // transmit drain
                            if (r_tx_fill == '0) begin
                                o_res_push = 1'b1;
                            end else begin
                                tx_re   = 1'b1;
                                n_state = ST_TX_READ;
                            end
                        end
                    endcase
                end
            end
            ST_RX_READ: begin
                o_res.rd_data  = r_rx_rdata;
                o_res.rd_valid = 1'b1;
                o_res_push     = 1'b1;
                if (!r_peek) begin
                    n_rx_tail = ring_next(r_rx_tail);
                    n_rx_fill = r_rx_fill - 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_TX_READ: begin
                o_res.tx_data  = r_tx_rdata;
                o_res.tx_valid = 1'b1;
                o_res_push     = 1'b1;
                n_tx_tail      = ring_next(r_tx_tail);
                n_tx_fill      = r_tx_fill - 1'b1;
                n_state        = ST_IDLE;
            end
            ST_CR: begin
                // newline already queued; carriage return only if room is left
                if (!tx_full) begin
                    tx_we          = 1'b1;
                    tx_wdata       = urb_pkg::BYTE_CR;
                    n_tx_head      = ring_next(r_tx_head);
                    n_tx_fill      = r_tx_fill + 1'b1;
                    o_res.accepted = 1'b1;
                end
                o_res_push = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // pattern or length change restarts the matcher
        if (i_cfg_we && ((i_cfg_index == urb_pkg::CFG_MAGIC_PATTERN) ||
                         (i_cfg_index == urb_pkg::CFG_MAGIC_LENGTH))) begin
            n_match_pos = 4'd0;
        end
        o_res.rx_fill = to_count(n_rx_fill);
        o_res.tx_room = to_count(LAST - n_tx_fill);
    end

    // receive ring memory
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_head] <= i_cmd.data;
        end
        if (rx_re) begin
            r_rx_rdata <= r_rx_mem[r_rx_tail];
        end
    end

    // transmit ring memory
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_head] <= tx_wdata;
        end
        if (tx_re) begin
            r_tx_rdata <= r_tx_mem[r_tx_tail];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newline_expand <= 1'b1;
            r_magic_pattern  <= '0;
            r_magic_length   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                urb_pkg::CFG_NEWLINE_EXPAND: r_newline_expand <= i_cfg_data[0];
                urb_pkg::CFG_MAGIC_PATTERN:  r_magic_pattern  <= i_cfg_data;
                urb_pkg::CFG_MAGIC_LENGTH:   r_magic_length   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_fill   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_fill   <= '0;
            r_sticky    <= urb_pkg::ERR_NONE;
            r_match_pos <= '0;
            r_peek      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_fill   <= n_rx_fill;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_fill   <= n_tx_fill;
            r_sticky    <= n_sticky;
            r_match_pos <= n_match_pos;
            r_peek      <= n_peek;
        end
    end

endmodule

FILE: sv/urb_outq.sv
// ----------------------------------------------------------------------------
// urb_outq
// Result queue: holds finished results until the consumer takes them, so
// the back end keeps working while a result waits.
// ----------------------------------------------------------------------------
module urb_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  urb_pkg::t_result  i_res,
    input  logic              pop,
    output urb_pkg::t_result  o_res,
    output urb_pkg::t_q_status o_status
);

    urb_pkg::t_result                r_q [urb_pkg::QUEUE_DEPTH];
    logic [urb_pkg::QUEUE_PW-1:0]    r_wr_ptr;
    logic [urb_pkg::QUEUE_PW-1:0]    r_rd_ptr;
    logic [urb_pkg::QUEUE_CW-1:0]    r_count;
    logic [urb_pkg::QUEUE_CW-1:0]    n_count;
    logic                            pop_ok;

    assign o_status.full  = (r_count == urb_pkg::QUEUE_CW'(urb_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign pop_ok         = pop && !o_status.empty;
    assign o_res          = r_q[r_rd_ptr];

    // occupancy
    always_comb begin
        case ({i_push, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: sv/uart_ring_buffer_engine.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine
// Receive and transmit ring buffers between a UART and software, with a
// sticky error status and a magic sequence matcher.
// ----------------------------------------------------------------------------
// Items enter through a two-entry command queue and leave through a
// two-entry result queue, one result for every item, in order. The back end
// executes one command at a time: a received word, a read that finds an
// error or an empty ring, a drain of an empty ring and a write without an
// added carriage return finish in the idle state; a read or drain that
// returns a byte passes through a read state, since the ring memories have a
// registered read port; a newline write with carriage return expansion
// passes through the carriage return state, one write per state on the
// single memory write port. The rings need no clearing after reset: the fill
// counts keep unwritten entries from being read. Each ring holds at most
// RING_DEPTH-1 bytes; the count ports show the low ten bits of the counts.
// Configuration must be written only while no item is in flight; not enforced.
module uart_ring_buffer_engine #(
    parameter int RING_DEPTH = 1024,
    parameter int MAGIC_MAX  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_op,
    input  logic [11:0]                     i_rx_word,
    input  logic [7:0]                      i_data_in,
    input  logic                            i_peek_only,
    // result channel
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_rd_data,
    output logic                            o_rd_valid,
    output logic [2:0]                      o_error_code,
    output logic                            o_accepted,
    output logic                            o_magic_hit,
    output logic [7:0]                      o_tx_data,
    output logic                            o_tx_valid,
    output logic [urb_pkg::COUNT_W-1:0]     o_rx_fill,
    output logic [urb_pkg::COUNT_W-1:0]     o_tx_room,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [urb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [urb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    urb_pkg::t_cmd      cmd;
    logic               cmd_valid;
    logic               cmd_pop;
    logic               res_push;
    urb_pkg::t_result   res_in;
    urb_pkg::t_result   res_out;
    urb_pkg::t_q_status outq_status;

    // front end: accept and classify
    urb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_op        (i_op),
        .i_rx_word   (i_rx_word),
        .i_data_in   (i_data_in),
        .i_peek_only (i_peek_only),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // back end: rings, error status, matcher
    urb_back #(
        .RING_DEPTH (RING_DEPTH),
        .MAGIC_MAX  (MAGIC_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_res_room  (!outq_status.full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue
    urb_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_res    (res_in),
        .pop      (pop),
        .o_res    (res_out),
        .o_status (outq_status)
    );

    assign empty        = outq_status.empty;
    assign o_rd_data    = res_out.rd_data;
    assign o_rd_valid   = res_out.rd_valid;
    assign o_error_code = res_out.error_code;
    assign o_accepted   = res_out.accepted;
    assign o_magic_hit  = res_out.magic_hit;
    assign o_tx_data    = res_out.tx_data;
    assign o_tx_valid   = res_out.tx_valid;
    assign o_rx_fill    = res_out.rx_fill;
    assign o_tx_room    = res_out.tx_room;

    // a result transfer into the result queue never finds it full
    a_no_outq_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !outq_status.full)
        else $error("result pushed into full result queue");

    // a command is only taken from the front end when one is waiting
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty command queue");

    // a read gives either an error or a byte, never both
    a_err_or_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_rd_valid && (o_error_code != urb_pkg::ERR_NONE)))
        else $error("read result carries both error and byte");

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

FILE: test/tb_uart_ring_buffer_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_ring_buffer_engine
// Self-checking bench for the UART ring buffer engine. A short table of
// directed transfers covers empty rings, error priority and clearing, peek,
// the magic matcher and carriage return expansion. Randomised phases then
// fill and drain both rings under varying idle and stall patterns. Every
// result is checked field by field against a cycle-free model of the rings.
// ----------------------------------------------------------------------------
module tb_uart_ring_buffer_engine;

    localparam int RING_DEPTH = 1024;
    localparam int MAGIC_MAX  = 8;
    // index with no register behind it, writes are dropped
    localparam logic [urb_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] rx_word;
        logic [7:0]  data_in;
        logic        peek;
    } t_request;

    typedef struct {
        bit                              is_reg;
        logic [urb_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [urb_pkg::CFG_DATA_W-1:0]  reg_value;
        t_request                        req;
        bit                              typed;
        urb_pkg::t_result                want;
    } t_dir_row;

    // DUT ports
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    logic [1:0]                      i_op;
    logic [11:0]                     i_rx_word;
    logic [7:0]                      i_data_in;
    logic                            i_peek_only;
    logic                            empty;
    logic                            pop;
    logic [7:0]                      o_rd_data;
    logic                            o_rd_valid;
    logic [2:0]                      o_error_code;
    logic                            o_accepted;
    logic                            o_magic_hit;
    logic [7:0]                      o_tx_data;
    logic                            o_tx_valid;
    logic [urb_pkg::COUNT_W-1:0]     o_rx_fill;
    logic [urb_pkg::COUNT_W-1:0]     o_tx_room;
    logic                            i_cfg_we;
    logic [urb_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [urb_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // shadow of the rings, status and registers
    logic [7:0]                     rx_store [RING_DEPTH];
    logic [7:0]                     tx_store [RING_DEPTH];
    int unsigned                    rx_wr_ptr = 0;
    int unsigned                    rx_rd_ptr = 0;
    int unsigned                    tx_wr_ptr = 0;
    int unsigned                    tx_rd_ptr = 0;
    logic [2:0]                     held_error = urb_pkg::ERR_NONE;
    int unsigned                    match_pos = 0;
    logic                           cr_after_nl = 1'b1;
    logic [urb_pkg::CFG_DATA_W-1:0] magic_bytes = '0;
    logic [3:0]                     magic_len = '0;

    urb_pkg::t_result awaited_results [$];
    t_dir_row         opening_rows [$];
    int               fail_count = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    uart_ring_buffer_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_rx_word    (i_rx_word),
        .i_data_in    (i_data_in),
        .i_peek_only  (i_peek_only),
        .empty        (empty),
        .pop          (pop),
        .o_rd_data    (o_rd_data),
        .o_rd_valid   (o_rd_valid),
        .o_error_code (o_error_code),
        .o_accepted   (o_accepted),
        .o_magic_hit  (o_magic_hit),
        .o_tx_data    (o_tx_data),
        .o_tx_valid   (o_tx_valid),
        .o_rx_fill    (o_rx_fill),
        .o_tx_room    (o_tx_room),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ring pointer helpers
    function automatic int unsigned ring_advance(int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_count(int unsigned wr, int unsigned rd);
        return (wr + RING_DEPTH - rd) % RING_DEPTH;
    endfunction

    // first error wins until a read clears it
    function automatic void hold_error(logic [2:0] code);
        if (held_error == urb_pkg::ERR_NONE)
            held_error = code;
    endfunction

    function automatic bit tx_enqueue(logic [7:0] b);
        int unsigned nxt;
        nxt = ring_advance(tx_wr_ptr);
        if (nxt == tx_rd_ptr)
            return 1'b0;
        tx_store[tx_wr_ptr] = b;
        tx_wr_ptr = nxt;
        return 1'b1;
    endfunction

    function automatic void apply_reg_write(logic [urb_pkg::CFG_INDEX_W-1:0] idx,
                                            logic [urb_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            urb_pkg::CFG_NEWLINE_EXPAND: cr_after_nl = val[0];
            urb_pkg::CFG_MAGIC_PATTERN: begin
                magic_bytes = val;
                match_pos   = 0;
            end
            urb_pkg::CFG_MAGIC_LENGTH: begin
                magic_len = val[3:0];
                match_pos = 0;
            end
            default: ;
        endcase
    endfunction

    // advance the shadow state by one transfer and return its result
    function automatic urb_pkg::t_result ring_step_outcome(t_request rq);
        urb_pkg::t_result r;
        logic [7:0]       b;
        int unsigned      len_eff;
        int unsigned      pos;
        int unsigned      nxt;
        bit               ok;
        r = '0;
        b = rq.rx_word[7:0];
        case (rq.op)
            urb_pkg::OP_RX_WORD: begin
                // one flag only, in priority order
                if (rq.rx_word[urb_pkg::RXW_BREAK_BIT])
                    hold_error(urb_pkg::ERR_BREAK);
                else if (rq.rx_word[urb_pkg::RXW_OVERRUN_BIT])
                    hold_error(urb_pkg::ERR_OVERRUN);
                else if (rq.rx_word[urb_pkg::RXW_FRAMING_BIT])
                    hold_error(urb_pkg::ERR_FRAMING);
                else if (rq.rx_word[urb_pkg::RXW_PARITY_BIT])
                    hold_error(urb_pkg::ERR_PARITY);
                // naive matcher: a mismatch restarts without rechecking the byte
                len_eff = (magic_len > MAGIC_MAX) ? MAGIC_MAX : magic_len;
                if (len_eff != 0) begin
                    pos = (match_pos >= len_eff) ? 0 : match_pos;
                    if (b == magic_bytes[8*pos +: 8]) begin
                        pos++;
                        if (pos >= len_eff) begin
                            r.magic_hit = 1'b1;
                            pos = 0;
                        end
                    end else begin
                        pos = 0;
                    end
                    match_pos = pos;
                end
                // full ring drops the byte and flags overrun
                nxt = ring_advance(rx_wr_ptr);
                if (nxt != rx_rd_ptr) begin
                    rx_store[rx_wr_ptr] = b;
                    rx_wr_ptr = nxt;
                end else begin
                    hold_error(urb_pkg::ERR_OVERRUN);
                end
            end
            urb_pkg::OP_READ: begin
                if (held_error != urb_pkg::ERR_NONE) begin
                    r.error_code = held_error;
                    held_error = urb_pkg::ERR_NONE;
                end else if (rx_wr_ptr != rx_rd_ptr) begin
                    r.rd_data  = rx_store[rx_rd_ptr];
                    r.rd_valid = 1'b1;
                    if (!rq.peek)
                        rx_rd_ptr = ring_advance(rx_rd_ptr);
                end
            end
            urb_pkg::OP_WRITE: begin
                ok = tx_enqueue(rq.data_in);
                if (ok && rq.data_in == urb_pkg::BYTE_NL && cr_after_nl)
                    ok = tx_enqueue(urb_pkg::BYTE_CR);
                r.accepted = ok;
            end
            default: begin
                if (tx_wr_ptr != tx_rd_ptr) begin
                    r.tx_data  = tx_store[tx_rd_ptr];
                    r.tx_valid = 1'b1;
                    tx_rd_ptr = ring_advance(tx_rd_ptr);
                end
            end
        endcase
        r.rx_fill = urb_pkg::COUNT_W'(ring_count(rx_wr_ptr, rx_rd_ptr));
        r.tx_room = urb_pkg::COUNT_W'(RING_DEPTH - 1 - ring_count(tx_wr_ptr, tx_rd_ptr));
        return r;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want,
                                          logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // directed table builders
    function automatic t_dir_row op_row(logic [1:0] op, logic [11:0] word,
                                        logic [7:0] din, logic peek);
        t_dir_row row;
        row.is_reg    = 1'b0;
        row.reg_index = '0;
        row.reg_value = '0;
        row.req       = '{op, word, din, peek};
        row.typed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    // result known by inspection: only error code and fill, tx ring empty
    function automatic t_dir_row status_row(logic [1:0] op, logic [11:0] word,
                                            logic peek, logic [2:0] err,
                                            int unsigned fill);
        t_dir_row row;
        row = op_row(op, word, 8'h00, peek);
        row.typed           = 1'b1;
        row.want.error_code = err;
        row.want.rx_fill    = urb_pkg::COUNT_W'(fill);
        row.want.tx_room    = urb_pkg::COUNT_W'(RING_DEPTH - 1);
        return row;
    endfunction

    function automatic t_dir_row reg_row(logic [urb_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [urb_pkg::CFG_DATA_W-1:0] val);
        t_dir_row row;
        row = op_row(urb_pkg::OP_RX_WORD, '0, '0, 1'b0);
        row.is_reg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    // one input transfer, with random idle cycles in front of it
    task automatic send_request(t_request rq, bit typed, urb_pkg::t_result typed_want);
        urb_pkg::t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_op        <= rq.op;
        i_rx_word   <= rq.rx_word;
        i_data_in   <= rq.data_in;
        i_peek_only <= rq.peek;
        do @(posedge i_clk); while (full);
        predicted = ring_step_outcome(rq);
        awaited_results.push_back(typed ? typed_want : predicted);
    endtask

    // let everything in flight come out before touching registers
    task automatic settle();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [urb_pkg::CFG_INDEX_W-1:0] idx,
                             logic [urb_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_reg_write(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random traffic with a given op mix; drain takes the remaining share
    task automatic run_phase(int count, int idle_pct, int stall_pct,
                             int w_rx, int w_read, int w_write);
        t_request rq;
        int       roll;
        int       len_eff;
        int       seq_left;
        int       seq_pos;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        len_eff  = (magic_len > MAGIC_MAX) ? MAGIC_MAX : magic_len;
        seq_left = 0;
        seq_pos  = 0;
        for (int n = 0; n < count; n++) begin
            roll  = $urandom_range(99);
            rq.op = (roll < w_rx) ? urb_pkg::OP_RX_WORD :
                    (roll < w_rx + w_read) ? urb_pkg::OP_READ :
                    (roll < w_rx + w_read + w_write) ? urb_pkg::OP_WRITE :
                    urb_pkg::OP_DRAIN;
            // mostly clean words so that bytes reach the reader
            rq.rx_word = 12'($urandom_range(4095));
            if ($urandom_range(99) < 85)
                rq.rx_word[11:8] = 4'b0000;
            // runs of pattern bytes, now and then corrupted
            if (rq.op == urb_pkg::OP_RX_WORD && len_eff != 0) begin
                if (seq_left == 0 && $urandom_range(99) < 30) begin
                    seq_left = len_eff;
                    seq_pos  = 0;
                end
                if (seq_left != 0) begin
                    if ($urandom_range(99) >= 8)
                        rq.rx_word[7:0] = magic_bytes[8*seq_pos +: 8];
                    seq_pos++;
                    seq_left--;
                end
            end
            rq.data_in = ($urandom_range(99) < 30) ? urb_pkg::BYTE_NL :
                         8'($urandom_range(255));
            rq.peek    = 1'($urandom_range(1));
            send_request(rq, 1'b0, '0);
        end
        settle();
    endtask

    // result side: check each transfer, then decide on the next pop
    initial begin : result_side
        urb_pkg::t_result want;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $error("result transfer with nothing pending");
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("rd_data", 16'(want.rd_data), 16'(o_rd_data));
                    compare_field("rd_valid", 16'(want.rd_valid), 16'(o_rd_valid));
                    compare_field("error_code", 16'(want.error_code), 16'(o_error_code));
                    compare_field("accepted", 16'(want.accepted), 16'(o_accepted));
                    compare_field("magic_hit", 16'(want.magic_hit), 16'(o_magic_hit));
                    compare_field("tx_data", 16'(want.tx_data), 16'(o_tx_data));
                    compare_field("tx_valid", 16'(want.tx_valid), 16'(o_tx_valid));
                    compare_field("rx_fill", 16'(want.rx_fill), 16'(o_rx_fill));
                    compare_field("tx_room", 16'(want.tx_room), 16'(o_tx_room));
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        logic [urb_pkg::CFG_DATA_W-1:0] reg_val;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_op        <= urb_pkg::OP_RX_WORD;
        i_rx_word   <= '0;
        i_data_in   <= '0;
        i_peek_only <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= urb_pkg::CFG_NEWLINE_EXPAND;
        i_cfg_data  <= '0;

        // empty rings straight after reset
        opening_rows.push_back(status_row(urb_pkg::OP_READ, '0, 1'b0,
                                          urb_pkg::ERR_NONE, 0));
        opening_rows.push_back(status_row(urb_pkg::OP_DRAIN, '0, 1'b0,
                                          urb_pkg::ERR_NONE, 0));
        // all flags at once: break wins
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h000, 8'h00, 1'b0));
        opening_rows.push_back(status_row(urb_pkg::OP_RX_WORD, 12'hFFF, 1'b0,
                                          urb_pkg::ERR_NONE, 2));
        // pending error beats a peek, then peek and pop
        opening_rows.push_back(status_row(urb_pkg::OP_READ, '0, 1'b1,
                                          urb_pkg::ERR_BREAK, 2));
        opening_rows.push_back(op_row(urb_pkg::OP_READ, '0, 8'h00, 1'b1));
        opening_rows.push_back(op_row(urb_pkg::OP_READ, '0, 8'h00, 1'b0));
        // overrun flag latched, later flags ignored until cleared
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h8A5, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h3C3, 8'h00, 1'b0));
        opening_rows.push_back(status_row(urb_pkg::OP_READ, '0, 1'b0,
                                          urb_pkg::ERR_OVERRUN, 3));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h15A, 8'h00, 1'b0));
        opening_rows.push_back(status_row(urb_pkg::OP_READ, '0, 1'b0,
                                          urb_pkg::ERR_FRAMING, 4));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h25A, 8'h00, 1'b0));
        opening_rows.push_back(status_row(urb_pkg::OP_READ, '0, 1'b0,
                                          urb_pkg::ERR_PARITY, 5));
        // two-byte pattern: mismatch restart, hit, restart on length write
        opening_rows.push_back(reg_row(urb_pkg::CFG_MAGIC_PATTERN, 64'h4241));
        opening_rows.push_back(reg_row(urb_pkg::CFG_MAGIC_LENGTH, 64'd2));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h041, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h041, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h041, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h042, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h041, 8'h00, 1'b0));
        opening_rows.push_back(reg_row(urb_pkg::CFG_MAGIC_LENGTH, 64'd2));
        opening_rows.push_back(op_row(urb_pkg::OP_RX_WORD, 12'h042, 8'h00, 1'b0));
        // newline with and without carriage return expansion
        opening_rows.push_back(reg_row(urb_pkg::CFG_NEWLINE_EXPAND, 64'd0));
        opening_rows.push_back(op_row(urb_pkg::OP_WRITE, '0, urb_pkg::BYTE_NL, 1'b0));
        opening_rows.push_back(reg_row(urb_pkg::CFG_NEWLINE_EXPAND, 64'd1));
        opening_rows.push_back(op_row(urb_pkg::OP_WRITE, '0, urb_pkg::BYTE_NL, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_WRITE, '0, 8'hFF, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_DRAIN, '0, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_DRAIN, '0, 8'h00, 1'b0));
        opening_rows.push_back(op_row(urb_pkg::OP_DRAIN, '0, 8'h00, 1'b0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (opening_rows[k]) begin
            if (opening_rows[k].is_reg) begin
                settle();
                write_reg(opening_rows[k].reg_index, opening_rows[k].reg_value);
            end else begin
                send_request(opening_rows[k].req, opening_rows[k].typed,
                             opening_rows[k].want);
            end
        end
        settle();

        // balanced traffic, no idling, three-byte pattern
        write_reg(urb_pkg::CFG_NEWLINE_EXPAND, 64'd1);
        write_reg(urb_pkg::CFG_MAGIC_PATTERN, {$urandom(), $urandom()});
        write_reg(urb_pkg::CFG_MAGIC_LENGTH, 64'd3);
        run_phase(80, 0, 0, 30, 30, 20);

        // receive-heavy with an idle sender: fills the receive ring to overrun
        write_reg(urb_pkg::CFG_MAGIC_PATTERN, '1);
        reg_val      = {$urandom(), $urandom()};
        reg_val[3:0] = 4'd8;
        write_reg(urb_pkg::CFG_MAGIC_LENGTH, reg_val);
        run_phase(1100, 82, 0, 98, 1, 1);

        // read-heavy with a stalling receiver, matcher off, no expansion
        write_reg(urb_pkg::CFG_NEWLINE_EXPAND, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(urb_pkg::CFG_MAGIC_LENGTH, 64'd0);
        write_reg(urb_pkg::CFG_MAGIC_PATTERN, 64'd0);
        run_phase(250, 0, 82, 6, 88, 3);

        // write-heavy, both sides idling: builds up the transmit ring
        reg_val    = {$urandom(), $urandom()};
        reg_val[0] = 1'b1;
        write_reg(urb_pkg::CFG_NEWLINE_EXPAND, reg_val);
        write_reg(CFG_SPARE_INDEX, {$urandom(), $urandom()});
        write_reg(urb_pkg::CFG_MAGIC_PATTERN, {$urandom(), $urandom()});
        write_reg(urb_pkg::CFG_MAGIC_LENGTH, 64'd1);
        run_phase(250, 27, 27, 3, 3, 92);

        // drain-leaning mix, no idling, length above the maximum
        write_reg(urb_pkg::CFG_MAGIC_LENGTH, 64'd15);
        write_reg(urb_pkg::CFG_MAGIC_PATTERN, {$urandom(), $urandom()});
        write_reg(urb_pkg::CFG_NEWLINE_EXPAND, {$urandom(), $urandom()});
        run_phase(100, 0, 0, 25, 25, 10);

        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
